### sv/rlpq_pkg.sv
// Package for the run-length packed queue.
// Holds item types, status and operation codes, run caps and ring handshake structs.
// No dependencies.
package rlpq_pkg;

    typedef enum logic [0:0] {
        OP_APPEND = 1'b0,
        OP_TAKE   = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT,
        S_HDR,
        S_VAL,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op         operation;
        logic [31:0] value;
    } t_in;

    typedef struct packed {
        logic [31:0] taken_value;
        t_status     status;
        logic        now_empty;
    } t_out;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] wdata;
    } t_ring_cmd;

    typedef struct packed {
        logic room;
        logic has_bytes;
    } t_ring_stat;

    localparam logic [7:0] NONZERO_CAP = 8'd32;
    localparam logic [7:0] ZERO_CAP    = 8'd127;
    localparam int         FLUSH_ROOM  = 5;

endpackage

### sv/rlpq_ring.sv
// Byte ring of the run-length packed queue: one memory, write and read pointers, fill count.
// Read data is the byte at the read pointer, registered.
// Depends on rlpq_pkg.
module rlpq_ring #(
    parameter int RING_BYTES = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rlpq_pkg::t_ring_cmd    i_cmd,
    output rlpq_pkg::t_ring_stat   o_stat,
    output logic [7:0]             o_rdata
);
    import rlpq_pkg::*;

    localparam int PW = $clog2(RING_BYTES);
    localparam int UW = $clog2(RING_BYTES + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(RING_BYTES - 1);
    localparam logic [UW-1:0] ROOM_MAX = UW'(RING_BYTES - FLUSH_ROOM);
    localparam logic [UW-1:0] FULL_CNT = UW'(RING_BYTES);

    logic [7:0]    r_mem [RING_BYTES];
    logic [7:0]    r_rdata;
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [UW-1:0] r_used, n_used;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_wr_ptr] <= i_cmd.wdata;
        end
        r_rdata <= r_mem[r_rd_ptr];
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_used   = r_used;
        if (i_cmd.push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_cmd.pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
        end
        case ({i_cmd.push, i_cmd.pop})
            2'b10:   n_used = r_used + UW'(1);
            2'b01:   n_used = r_used - UW'(1);
            default: n_used = r_used;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_used   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_used   <= n_used;
        end
    end

    assign o_stat.room      = (r_used <= ROOM_MAX);
    assign o_stat.has_bytes = (r_used != '0);
    assign o_rdata          = r_rdata;

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> r_used != FULL_CNT)
        else $error("push into full ring");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> r_used != '0)
        else $error("pop from empty ring");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push && !i_cmd.pop) |=> r_used == $past(r_used) + UW'(1))
        else $error("fill count did not advance on push");
`endif

endmodule

### sv/run_length_packed_queue.sv
// An accepted item ends in a registered result; an append that closes a run first writes
// its ring bytes (1 to 5), and a take that opens a run first reads its ring bytes (1 to 5).
// The single byte port of the ring sets the pace; a new item waits until the last one is done.
// The next item is accepted while a result waits; its own result waits for the register.
// Reset (synchronous, active low) clears run registers, pointers and fill count;
// ring contents are left as they are and need no clearing pass.
module run_length_packed_queue #(
    parameter int RING_BYTES = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  rlpq_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output rlpq_pkg::t_out  o_out
);
    import rlpq_pkg::*;

    t_state      r_state, n_state;
    logic [31:0] r_open_val, n_open_val;
    logic [6:0]  r_open_cnt, n_open_cnt;
    logic [31:0] r_front_val, n_front_val;
    logic [6:0]  r_front_left, n_front_left;
    logic [39:0] r_bytes, n_bytes;
    logic [2:0]  r_nbytes, n_nbytes;
    logic [1:0]  r_vidx, n_vidx;
    logic [1:0]  r_vlast, n_vlast;
    logic        r_vgot, n_vgot;
    logic [31:0] r_res_val, n_res_val;
    t_status     r_res_st, n_res_st;
    t_out        r_out, n_out;
    logic        r_out_valid, n_out_valid;

    t_ring_cmd   ring_cmd;
    t_ring_stat  ring_stat;
    logic [7:0]  ring_rdata;

    logic        in_acc, out_free;
    logic        same, in_zero, cap_hit, app_first, app_flush, app_emit;
    logic        take_front, take_ring;
    logic [7:0]  cnt_inc, cap, emit_cnt;
    logic [1:0]  size_m1;
    logic [7:0]  header;
    logic [7:0]  vbyte;
    logic        now_empty;

    rlpq_ring #(.RING_BYTES(RING_BYTES)) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (ring_cmd),
        .o_stat  (ring_stat),
        .o_rdata (ring_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign same      = (i_in.value == r_open_val);
    assign in_zero   = (i_in.value == 32'd0);
    assign cnt_inc   = {1'b0, r_open_cnt} + 8'd1;
    assign cap       = in_zero ? ZERO_CAP : NONZERO_CAP;
    assign cap_hit   = same && (cnt_inc >= cap);
    assign app_first = (r_open_cnt == 7'd0);
    assign app_flush = !app_first && (!same || cap_hit);
    assign app_emit  = app_flush && ring_stat.room;
    assign emit_cnt  = cap_hit ? cap : {1'b0, r_open_cnt};

    assign take_front = (r_front_left != 7'd0);
    assign take_ring  = !take_front && ring_stat.has_bytes;

    assign now_empty = !take_front && !ring_stat.has_bytes && (r_open_cnt == 7'd0);
    assign vbyte     = r_vgot ? ring_rdata : 8'd0;

    always_comb begin
        if (r_open_val[31:24] != 8'd0) begin
            size_m1 = 2'd3;
        end else if (r_open_val[23:16] != 8'd0) begin
            size_m1 = 2'd2;
        end else if (r_open_val[15:8] != 8'd0) begin
            size_m1 = 2'd1;
        end else begin
            size_m1 = 2'd0;
        end
        header = {1'b1, size_m1, 5'(emit_cnt - 8'd1)};
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.operation == OP_APPEND) begin
                        n_state = app_emit ? S_EMIT : S_DONE;
                    end else begin
                        n_state = take_ring ? S_HDR : S_DONE;
                    end
                end
            end
            S_EMIT: n_state = (r_nbytes == 3'd1) ? S_DONE : S_EMIT;
            S_HDR:  n_state = ring_rdata[7] ? S_VAL : S_DONE;
            S_VAL:  n_state = (r_vidx == r_vlast) ? S_DONE : S_VAL;
            S_DONE: n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and ring commands
    always_comb begin
        n_open_val   = r_open_val;
        n_open_cnt   = r_open_cnt;
        n_front_val  = r_front_val;
        n_front_left = r_front_left;
        n_bytes      = r_bytes;
        n_nbytes     = r_nbytes;
        n_vidx       = r_vidx;
        n_vlast      = r_vlast;
        n_vgot       = r_vgot;
        n_res_val    = r_res_val;
        n_res_st     = r_res_st;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;
        ring_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res_val = 32'd0;
                    n_res_st  = ST_OK;
                    if (i_in.operation == OP_APPEND) begin
                        if (app_first) begin
                            n_open_val = i_in.value;
                            n_open_cnt = 7'd1;
                        end else if (!app_flush) begin
                            n_open_cnt = cnt_inc[6:0];
                        end else if (!ring_stat.room) begin
                            n_res_st = ST_FULL;
                        end else begin
                            if (r_open_val == 32'd0) begin
                                n_bytes  = {33'd0, emit_cnt[6:0]};
                                n_nbytes = 3'd1;
                            end else begin
                                n_bytes  = {r_open_val, header};
                                n_nbytes = {1'b0, size_m1} + 3'd2;
                            end
                            if (cap_hit) begin
                                n_open_cnt = 7'd0;
                            end else begin
                                n_open_val = i_in.value;
                                n_open_cnt = 7'd1;
                            end
                        end
                    end else begin
                        if (take_front) begin
                            n_front_left = r_front_left - 7'd1;
                            n_res_val    = r_front_val;
                        end else if (take_ring) begin
                            ring_cmd.pop = 1'b1;
                        end else if (r_open_cnt != 7'd0) begin
                            n_open_cnt = r_open_cnt - 7'd1;
                            n_res_val  = r_open_val;
                        end else begin
                            n_res_st = ST_EMPTY;
                        end
                    end
                end
            end
            S_EMIT: begin
                ring_cmd.push  = 1'b1;
                ring_cmd.wdata = r_bytes[7:0];
                n_bytes        = {8'd0, r_bytes[39:8]};
                n_nbytes       = r_nbytes - 3'd1;
            end
            S_HDR: begin
                n_front_val = 32'd0;
                if (!ring_rdata[7]) begin
                    n_front_left = (ring_rdata == 8'd0) ? 7'd0 : ring_rdata[6:0] - 7'd1;
                    n_res_val    = 32'd0;
                end else begin
                    n_front_left = {2'b00, ring_rdata[4:0]};
                    n_vlast      = ring_rdata[6:5];
                    n_vidx       = 2'd0;
                    n_vgot       = ring_stat.has_bytes;
                    ring_cmd.pop = ring_stat.has_bytes;
                end
            end
            S_VAL: begin
                n_front_val[{r_vidx, 3'b000} +: 8] = vbyte;
                if (r_vidx == r_vlast) begin
                    n_res_val = n_front_val;
                end else begin
                    n_vidx       = r_vidx + 2'd1;
                    n_vgot       = ring_stat.has_bytes;
                    ring_cmd.pop = ring_stat.has_bytes;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out.taken_value = r_res_val;
                    n_out.status      = r_res_st;
                    n_out.now_empty   = now_empty;
                    n_out_valid       = 1'b1;
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_open_val   <= '0;
            r_open_cnt   <= '0;
            r_front_val  <= '0;
            r_front_left <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_open_val   <= n_open_val;
            r_open_cnt   <= n_open_cnt;
            r_front_val  <= n_front_val;
            r_front_left <= n_front_left;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes   <= n_bytes;
        r_nbytes  <= n_nbytes;
        r_vidx    <= n_vidx;
        r_vlast   <= n_vlast;
        r_vgot    <= n_vgot;
        r_res_val <= n_res_val;
        r_res_st  <= n_res_st;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef ASSERT_OFF
    a_fail_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK) |-> r_out.taken_value == 32'd0)
        else $error("failed item carries a value");
    a_empty_take_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_EMPTY) |-> r_out.now_empty)
        else $error("empty take reports a nonempty queue");
    a_open_below_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open_cnt != ZERO_CAP[6:0])
        else $error("open run reached its cap without flush");
    a_hdr_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HDR) |-> $past(ring_cmd.pop))
        else $error("header decode without a ring read");
`endif

endmodule
